@@ src/prh_pkg.sv @@
// Package for the pixel range histogram: sizes, request codes, command struct,
// back-end state type, pixel-to-bin table and bin bound functions.
// No dependencies.
`default_nettype none
package prh_pkg;

    localparam int BIN_WIDTH   = 10;
    localparam int NUM_BINS    = 25;
    localparam int COUNT_BITS  = 20;
    localparam int PIXEL_MAX   = 255;
    localparam int BIN_BITS    = $clog2(NUM_BINS);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [BIN_BITS-1:0]   t_bin;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [QPTR_BITS-1:0]  t_qptr;
    typedef logic [QPTR_BITS:0]    t_qfill;

    typedef enum logic {
        REQ_COUNT   = 1'b0,
        REQ_READOUT = 1'b1
    } t_req;

    typedef struct packed {
        t_req req;
        t_bin bin;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } t_state;

    localparam t_bin   LAST_BIN  = t_bin'(NUM_BINS - 1);
    localparam t_count COUNT_MAX = '1;

    typedef t_bin t_bin_tab [256];

    // Walk the pixel range once, stepping the bin every BIN_WIDTH values;
    // values past the last bin stay in it.
    function automatic t_bin_tab build_bin_tab();
        t_bin_tab tab;
        int       b;
        int       off;
        b   = 0;
        off = 0;
        for (int v = 0; v < 256; v++) begin
            tab[v] = t_bin'(b);
            off++;
            if (off == BIN_WIDTH) begin
                off = 0;
                if (b < NUM_BINS - 1) begin
                    b++;
                end
            end
        end
        return tab;
    endfunction

    localparam t_bin_tab BIN_TAB = build_bin_tab();

    // Lowest pixel value of a bin, clamped to the pixel range.
    function automatic logic [7:0] bin_low(input t_bin idx);
        int v;
        v = int'(idx) * BIN_WIDTH;
        return (v > PIXEL_MAX) ? 8'hFF : 8'(v);
    endfunction

    // Highest pixel value of a bin; the last bin runs to the top of the range.
    function automatic logic [7:0] bin_high(input t_bin idx);
        int v;
        v = (int'(idx) + 1) * BIN_WIDTH - 1;
        if (idx == LAST_BIN) begin
            return 8'hFF;
        end
        return (v > PIXEL_MAX) ? 8'hFF : 8'(v);
    endfunction

endpackage
`default_nettype wire

@@ src/prh_front.sv @@
// Front end: accepts request beats, maps the pixel to its bin and holds the
// classified command until the queue takes it. Depends on prh_pkg.
`default_nettype none
module prh_front import prh_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_pixel_value,
    output logic            o_push,
    output t_cmd            o_cmd,
    input  wire logic       i_full
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic w_load;

    // Stall only while the held command cannot move on
    assign o_in_stall = r_valid && i_full;
    assign w_load     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_valid = w_load ? 1'b1 : (r_valid && i_full);
    end

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Classify the beat
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd.req <= t_req'(i_req_type);
            r_cmd.bin <= BIN_TAB[i_pixel_value];
        end
    end

endmodule
`default_nettype wire

@@ src/prh_queue.sv @@
// Short command queue between the front and back ends.
// Depends on prh_pkg.
`default_nettype none
module prh_queue import prh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd   r_mem [QUEUE_DEPTH];
    t_qptr  r_wr;
    t_qptr  r_rd;
    t_qfill r_fill;
    logic   w_wr;
    logic   w_rd;

    assign o_full  = (r_fill == t_qfill'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_rd) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ src/prh_back.sv @@
// Back end: holds the bin counters, applies count commands and sequences a
// readout run through the output register. Depends on prh_pkg.
`default_nettype none
module prh_back import prh_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_cmd  i_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_stall,
    output logic [4:0] o_bin_index,
    output logic [7:0] o_bin_low,
    output logic [7:0] o_bin_high,
    output logic [19:0] o_bin_count,
    output logic       o_last_bin
);

    t_state r_state;
    t_state n_state;
    t_count r_cnt [NUM_BINS];
    t_bin   r_idx;
    logic   r_out_valid;
    t_bin   r_out_idx;
    t_count r_out_count;
    logic   w_out_free;
    logic   w_incr;
    logic   w_emit;
    logic   w_start;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty && i_cmd.req == REQ_READOUT) begin
                    n_state = ST_READOUT;
                end
            end
            ST_READOUT: begin
                if (w_out_free && r_idx == LAST_BIN) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop   = 1'b0;
        w_incr  = 1'b0;
        w_emit  = 1'b0;
        w_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop   = !i_empty;
                w_incr  = !i_empty && i_cmd.req == REQ_COUNT;
                w_start = !i_empty && i_cmd.req == REQ_READOUT;
            end
            ST_READOUT: begin
                w_emit = w_out_free;
            end
            default: ;
        endcase
    end

    // Advance state and readout index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_idx <= '0;
            end else if (w_emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Count with saturation; clear each bin as it is read out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (w_incr) begin
            if (r_cnt[i_cmd.bin] != COUNT_MAX) begin
                r_cnt[i_cmd.bin] <= r_cnt[i_cmd.bin] + 1'b1;
            end
        end else if (w_emit) begin
            r_cnt[r_idx] <= '0;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_idx   <= r_idx;
            r_out_count <= r_cnt[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = 5'(r_out_idx);
    assign o_bin_low   = bin_low(r_out_idx);
    assign o_bin_high  = bin_high(r_out_idx);
    assign o_bin_count = 20'(r_out_count);
    assign o_last_bin  = (r_out_idx == LAST_BIN);

endmodule
`default_nettype wire

@@ src/pixel_range_histogram.sv @@
// Pixel range histogram, top level: front end, command queue, back end.
// Depends on prh_pkg, prh_front, prh_queue and prh_back.
//
// Usage: the input channel carries one request per beat. req_type 0 counts
// pixel_value into its bin (bins of BIN_WIDTH values; the last bin also
// takes everything up to 255). req_type 1 reads out every bin in order,
// one output beat per bin with its bounds, count and last_bin on the final
// one, and clears the counters. Counters saturate at their maximum.
// Throughput: one count request per cycle while the command queue has room;
// a readout holds the back end while it takes the command and then reads
// one counter per cycle, plus any output stalls.
// Readout path: the request passes the front register, the queue, the
// back-end state register and the output register before its first beat.
// The front end keeps accepting requests during a readout until the
// command queue (QUEUE_DEPTH entries) and the front register fill up.
// A stalled output beat holds, and the readout sequencer waits on it.
// Reset (synchronous, active low) clears all counters, the queue and the
// output valid flag at once; the block accepts beats on the next cycle.
`default_nettype none
module pixel_range_histogram import prh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_pixel_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_bin_index,
    output logic [7:0]       o_bin_low,
    output logic [7:0]       o_bin_high,
    output logic [19:0]      o_bin_count,
    output logic             o_last_bin
);

    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_cmd w_head_cmd;

    prh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_pixel_value (i_pixel_value),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_full        (w_full)
    );

    prh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    prh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_bin_index (o_bin_index),
        .o_bin_low   (o_bin_low),
        .o_bin_high  (o_bin_high),
        .o_bin_count (o_bin_count),
        .o_last_bin  (o_last_bin)
    );

endmodule
`default_nettype wire

@@ src/prh_checker.sv @@
// Port-level checks for the pixel range histogram, bound to the top level.
// Depends on prh_pkg and pixel_range_histogram.
`default_nettype none
module prh_checker import prh_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [4:0]  o_bin_index,
    input wire logic [7:0]  o_bin_low,
    input wire logic [7:0]  o_bin_high,
    input wire logic [19:0] o_bin_count,
    input wire logic        o_last_bin
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_bin_index) && $stable(o_bin_count)
            && $stable(o_last_bin))
        else $error("stalled output beat changed");

    // No output beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // The last flag marks the top bin, which runs to 255
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_bin |->
            o_bin_index == 5'(LAST_BIN) && o_bin_high == 8'hFF)
        else $error("last bin flag on wrong bin");

    // A readout run starts at the bottom of the range
    a_first_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bin_index == 5'd0 |-> o_bin_low == 8'd0 && !o_last_bin)
        else $error("first bin bounds wrong");

    // Bins follow in order once a beat is taken
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_bin ##1 o_out_valid |->
            o_bin_index == $past(o_bin_index) + 5'd1)
        else $error("readout bins out of order");

endmodule

bind pixel_range_histogram prh_checker u_prh_checker (.*);
`default_nettype wire

@@ tb/prh_histogram_monitor.sv @@
// Histogram monitor: watches the request and readout channels of the pixel
// range histogram, keeps its own bin tally and checks every readout beat.
// Depends on prh_pkg.
`timescale 1ns / 100ps
module prh_histogram_monitor import prh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_pixel_value,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [4:0]  i_bin_index,
    input  wire logic [7:0]  i_bin_low,
    input  wire logic [7:0]  i_bin_high,
    input  wire logic [19:0] i_bin_count,
    input  wire logic        i_last_bin,
    output int               o_fail_count,
    output int               o_reports_pending
);

    typedef struct {
        logic [4:0]  index;
        logic [7:0]  low;
        logic [7:0]  high;
        logic [19:0] count;
        logic        last;
    } t_bin_report;

    t_count      bin_tally [NUM_BINS];
    t_bin_report bin_reports_q [$];
    t_bin_report oldest;
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    // Add one pixel to its bin; everything past the last bin lands in it.
    function automatic void tally_pixel(input logic [7:0] pix);
        int b;
        b = int'(pix) / BIN_WIDTH;
        if (b > NUM_BINS - 1) begin
            b = NUM_BINS - 1;
        end
        if (bin_tally[b] != COUNT_MAX) begin
            bin_tally[b] = bin_tally[b] + 1'b1;
        end
    endfunction

    // Queue one report per bin with clamped bounds, then clear the tally.
    function automatic void queue_readout();
        t_bin_report rep;
        int          lo;
        int          hi;
        for (int i = 0; i < NUM_BINS; i++) begin
            lo = i * BIN_WIDTH;
            hi = (i + 1) * BIN_WIDTH - 1;
            if (lo > PIXEL_MAX) begin
                lo = PIXEL_MAX;
            end
            if (hi > PIXEL_MAX || i == NUM_BINS - 1) begin
                hi = PIXEL_MAX;
            end
            rep.index = 5'(i);
            rep.low   = 8'(lo);
            rep.high  = 8'(hi);
            rep.count = 20'(bin_tally[i]);
            rep.last  = (i == NUM_BINS - 1);
            bin_reports_q = {bin_reports_q, rep};
            bin_tally[i] = '0;
        end
    endfunction

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) begin
                bin_tally[i] = '0;
            end
            bin_reports_q.delete();
        end else begin
            // Check a readout beat against the oldest expected report
            if (i_out_valid && !i_out_stall) begin
                if (bin_reports_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected readout beat: expected none, actual bin %0d",
                             $time, i_bin_index);
                end else begin
                    oldest = bin_reports_q.pop_front();
                    check_field("bin_index", oldest.index, i_bin_index);
                    check_field("bin_low", oldest.low, i_bin_low);
                    check_field("bin_high", oldest.high, i_bin_high);
                    check_field("bin_count", oldest.count, i_bin_count);
                    check_field("last_bin", oldest.last, i_last_bin);
                end
            end
            // Advance the tally on an accepted request beat
            if (i_in_valid && !i_in_stall) begin
                if (i_req_type == REQ_READOUT) begin
                    queue_readout();
                end else begin
                    tally_pixel(i_pixel_value);
                end
            end
        end
        o_reports_pending <= bin_reports_q.size();
    end

endmodule

@@ tb/pixel_range_histogram_tb.sv @@
// Testbench top for the pixel range histogram: clock, reset, request bursts,
// readout stalls and the verdict. Depends on prh_pkg, pixel_range_histogram
// and prh_histogram_monitor.
`timescale 1ns / 100ps
module pixel_range_histogram_tb;
    import prh_pkg::*;

    localparam int RANDOM_BEATS = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_COUNT;
    logic [7:0]  pixel_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  bin_index;
    logic [7:0]  bin_low;
    logic [7:0]  bin_high;
    logic [19:0] bin_count;
    logic        last_bin;
    int          fail_count;
    int          reports_pending;
    logic [7:0]  prev_pixel = '0;
    logic [7:0]  stall_tick = '0;
    logic [1:0]  stall_mode = '0;

    always #5 clk = ~clk;

    pixel_range_histogram u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_pixel_value (pixel_value),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_bin_index   (bin_index),
        .o_bin_low     (bin_low),
        .o_bin_high    (bin_high),
        .o_bin_count   (bin_count),
        .o_last_bin    (last_bin)
    );

    prh_histogram_monitor u_monitor (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_req_type        (req_type),
        .i_pixel_value     (pixel_value),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_bin_index       (bin_index),
        .i_bin_low         (bin_low),
        .i_bin_high        (bin_high),
        .i_bin_count       (bin_count),
        .i_last_bin        (last_bin),
        .o_fail_count      (fail_count),
        .o_reports_pending (reports_pending)
    );

    // Present one request beat and hold it until the block takes it.
    // Valid stays high on return so back-to-back beats need no toggle.
    task automatic send_request(input t_req req, input logic [7:0] pix);
        in_valid    <= 1'b1;
        req_type    <= req;
        pixel_value <= pix;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (req == REQ_COUNT) begin
            prev_pixel = pix;
        end
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            in_valid    <= 1'b0;
            pixel_value <= 8'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stall the readout side: free-flowing, random, or long periodic holds
    always @(posedge clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[5:0] == 6'd0) begin
            stall_mode <= 2'($urandom_range(0, 2));
        end
        case (stall_mode)
            2'd0: begin
                out_stall <= 1'b0;
            end
            2'd1: begin
                out_stall <= ($urandom_range(0, 99) < 35);
            end
            default: begin
                out_stall <= (stall_tick[2:0] < 3'd5);
            end
        endcase
    end

    initial begin
        int          burst_len;
        int          sent;
        int          pick;
        logic [7:0]  pix;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bin edges, repeated bins, values past the nominal range
        send_request(REQ_COUNT, 8'd0);
        send_request(REQ_COUNT, 8'd9);
        send_request(REQ_COUNT, 8'd10);
        send_request(REQ_COUNT, 8'd19);
        send_request(REQ_COUNT, 8'd127);
        send_request(REQ_COUNT, 8'd127);
        send_request(REQ_COUNT, 8'd127);
        send_request(REQ_COUNT, 8'd128);
        send_request(REQ_COUNT, 8'd239);
        send_request(REQ_COUNT, 8'd240);
        send_request(REQ_COUNT, 8'd249);
        send_request(REQ_COUNT, 8'd250);
        send_request(REQ_COUNT, 8'd251);
        send_request(REQ_COUNT, 8'd255);
        send_request(REQ_COUNT, 8'd255);
        send_request(REQ_READOUT, 8'd255);
        // A second readout right away must report cleared counters
        send_request(REQ_READOUT, 8'd0);
        send_request(REQ_COUNT, 8'd5);
        send_request(REQ_COUNT, 8'd254);
        send_request(REQ_READOUT, 8'hAA);
        // Counts queued behind a readout belong to the next histogram
        send_request(REQ_COUNT, 8'd100);
        send_request(REQ_COUNT, 8'd100);
        send_request(REQ_COUNT, 8'd101);
        send_request(REQ_READOUT, 8'h55);
        idle_gap(3);

        // Random: bursts of pixels with repeats and top-range values
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(1, 12);
            for (int k = 0; k < burst_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_request(REQ_READOUT, 8'($urandom));
                end else begin
                    if (pick < 22) begin
                        pix = prev_pixel;
                    end else if (pick < 36) begin
                        pix = 8'($urandom_range(240, 255));
                    end else begin
                        pix = 8'($urandom);
                    end
                    send_request(REQ_COUNT, pix);
                end
                sent++;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        // Flush the final histogram
        send_request(REQ_READOUT, 8'($urandom));
        idle_gap(1);

        // Drain outstanding reports, then watch for strays
        while (reports_pending != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
src/prh_pkg.sv
src/prh_front.sv
src/prh_queue.sv
src/prh_back.sv
src/pixel_range_histogram.sv
src/prh_checker.sv
tb/prh_histogram_monitor.sv
tb/pixel_range_histogram_tb.sv
